### hw/rtl/i2c_target_register_map_macros.svh
// Assertion macros for the I2C target register map.
// Used by i2c_target_register_map.sv; needs clk_i and rst_ni in scope.
`ifndef I2C_TARGET_REGISTER_MAP_MACROS_SVH
`define I2C_TARGET_REGISTER_MAP_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define TRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("register map assertion failed");
// Checked at every edge, reset included.
`define TRM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("register map assertion failed");
`else
`define TRM_ASSERT(lbl, prop)
`define TRM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/trm_pkg.sv
// Package for the I2C target register map: word types, map addresses,
// command and phase codes and the name string. No dependencies.
`default_nettype none

package trm_pkg;

  localparam int NameLengthDefault  = 12;
  localparam int NumChannelsDefault = 4;

  localparam logic [15:0] NAME_BASE = 16'h0020;
  localparam logic [15:0] ADC_BASE  = 16'h0060;

  // Command byte that opens a pointer load.
  localparam logic [7:0] CMD_SET_POINTER = 8'h01;

  // Write phase codes.
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_PTR_HI = 2'd1;
  localparam logic [1:0] PHASE_PTR_LO = 2'd2;
  localparam logic [1:0] PHASE_DONE   = 2'd3;

  // Item opcodes.
  localparam logic OP_BUS_EVENT = 1'b0;
  localparam logic OP_ADC_UPD   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic        read_not_write;
    logic        data_not_address;
    logic        master_nack;
    logic [7:0]  rx_byte;
    logic [1:0]  channel;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_loaded;
  } out_item_t;

  // Byte of the name string at offset k; offsets past the text read as zero.
  function automatic logic [7:0] name_char(logic [4:0] k);
    logic [7:0] c;
    unique case (k)
      5'd0:    c = 8'h42; // B
      5'd1:    c = 8'h63; // c
      5'd2:    c = 8'h75; // u
      5'd3:    c = 8'h72; // r
      5'd4:    c = 8'h72; // r
      5'd5:    c = 8'h20; // space
      5'd6:    c = 8'h76; // v
      5'd7:    c = 8'h30; // 0
      5'd8:    c = 8'h30; // 0
      5'd9:    c = 8'h2E; // .
      5'd10:   c = 8'h30; // 0
      5'd11:   c = 8'h31; // 1
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/i2c_target_register_map.sv
// I2C target register map: decodes bus events and ADC updates into read data.
// Depends on trm_pkg and i2c_target_register_map_macros.svh.
//
// Path: a word accepted at an edge is registered in the input register, is
// processed from there, and its result word is held in the result register.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset clears the write phase, the pointer, the ADC results and both valid flags.
`default_nettype none

`include "i2c_target_register_map_macros.svh"

module i2c_target_register_map
  import trm_pkg::*;
#(
  parameter int NAME_LENGTH  = NameLengthDefault,
  parameter int NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // Exclusive upper bounds of the two readable windows, one bit wider than
  // the pointer so the compare never wraps.
  localparam logic [16:0] NAME_END = 17'(NAME_BASE) + 17'(NAME_LENGTH);
  localparam logic [16:0] ADC_END  = 17'(ADC_BASE) + 17'(2 * NUM_CHANNELS);

  // Input register.
  logic     in_valid_q;
  in_item_t in_item_q;

  // Result register.
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  // Register map state.
  logic [1:0]  phase_q, phase_d;
  logic [15:0] pointer_q, pointer_d;
  logic [15:0] chan_res_q [NUM_CHANNELS];

  // The pipeline moves when the result register can take a new word.
  logic advance, fire, in_load;
  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = in_valid_q && advance;
  assign in_load = in_valid_i && !in_stall_o;

  // The input side stalls only when it holds a word that cannot move on.
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
  end

  // Read decode of the current pointer. The name window is at most 32 bytes
  // from a 32-aligned base, so its low five pointer bits are the offset.
  logic        in_name, in_adc;
  logic [15:0] adc_off;
  logic [CH_IDX_W-1:0] adc_ch;
  logic [15:0] adc_word;
  logic [7:0]  read_byte;

  assign in_name = ({1'b0, pointer_q} >= 17'(NAME_BASE)) && ({1'b0, pointer_q} < NAME_END);
  assign in_adc  = ({1'b0, pointer_q} >= 17'(ADC_BASE)) && ({1'b0, pointer_q} < ADC_END);
  assign adc_off = pointer_q - ADC_BASE;
  assign adc_ch  = adc_off[CH_IDX_W:1];

  always_comb begin
    adc_word = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (adc_ch == CH_IDX_W'(i)) begin
        adc_word = chan_res_q[i];
      end
    end
  end

  // Even offsets give the high byte of a channel, odd offsets the low byte.
  always_comb begin
    priority if (in_name) begin
      read_byte = name_char(pointer_q[4:0]);
    end else if (in_adc) begin
      read_byte = adc_off[0] ? adc_word[7:0] : adc_word[15:8];
    end else begin
      read_byte = 8'h00;
    end
  end

  // Event decode for the word in the input register.
  logic is_bus, is_read, is_rd_done, is_rd_req, is_wr_data;
  assign is_bus     = (in_item_q.opcode == OP_BUS_EVENT);
  assign is_read    = is_bus && in_item_q.read_not_write;
  assign is_rd_done = is_read && in_item_q.data_not_address && in_item_q.master_nack;
  assign is_rd_req  = is_read && !is_rd_done;
  assign is_wr_data = is_bus && !in_item_q.read_not_write && in_item_q.data_not_address;

  // Pointer and phase update. A NACKed read completion clears both; a read
  // request moves the pointer on by one with 16-bit wrap; write data bytes
  // step the pointer-load sequence.
  always_comb begin
    phase_d   = phase_q;
    pointer_d = pointer_q;
    if (is_rd_done) begin
      phase_d   = PHASE_IDLE;
      pointer_d = '0;
    end else if (is_rd_req) begin
      pointer_d = pointer_q + 16'd1;
    end else if (is_wr_data) begin
      unique case (phase_q)
        PHASE_IDLE: begin
          if (in_item_q.rx_byte == CMD_SET_POINTER) begin
            phase_d = PHASE_PTR_HI;
          end
        end
        PHASE_PTR_HI: begin
          pointer_d = {8'h00, in_item_q.rx_byte};
          phase_d   = PHASE_PTR_LO;
        end
        PHASE_PTR_LO: begin
          pointer_d = {pointer_q[7:0], in_item_q.rx_byte};
          phase_d   = PHASE_DONE;
        end
        PHASE_DONE: begin
          phase_d = PHASE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_IDLE;
      pointer_q <= '0;
    end else if (fire) begin
      phase_q   <= phase_d;
      pointer_q <= pointer_d;
    end
  end

  // ADC results; an update for a channel beyond the last one matches no entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_res_q[i] <= '0;
      end
    end else if (fire && (in_item_q.opcode == OP_ADC_UPD)) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (32'(in_item_q.channel) == i) begin
          chan_res_q[i] <= in_item_q.sample;
        end
      end
    end
  end

  // Every word gives one result word; only a read request carries data.
  always_comb begin
    out_item_d.tx_byte   = is_rd_req ? read_byte : 8'h00;
    out_item_d.tx_loaded = is_rd_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A NACKed read completion leaves the pointer and phase cleared.
  `TRM_ASSERT(a_rd_done_clears, fire && is_rd_done |=> (pointer_q == '0) && (phase_q == PHASE_IDLE))
  // A read request always moves the pointer on by one.
  `TRM_ASSERT(a_rd_req_steps, fire && is_rd_req |=> pointer_q == $past(pointer_q) + 16'd1)
  // A result without data carries a zero byte.
  `TRM_ASSERT(a_idle_byte_zero, out_valid_o && !out_item_o.tx_loaded |-> out_item_o.tx_byte == 8'h00)
  // The input side only stalls while holding a word.
  `TRM_ASSERT_ALWAYS(a_stall_held, in_stall_o |-> in_valid_q)

endmodule

`default_nettype wire

### sim/i2c_target_register_map_test.sv
// Self-checking testbench for the I2C target register map: a directed table, then
// random pointer loads, read bursts, ADC updates and noise, with random idling on both sides.
// Depends on trm_pkg and the i2c_target_register_map RTL.
module i2c_target_register_map_test;
  import trm_pkg::*;

  // The name string, first character in the top byte.
  localparam int ID_TEXT_LEN = 12;
  localparam logic [8*ID_TEXT_LEN-1:0] ID_TEXT = {
    8'h42, 8'h63, 8'h75, 8'h72, 8'h72, 8'h20,
    8'h76, 8'h30, 8'h30, 8'h2E, 8'h30, 8'h31
  };
  localparam out_item_t NO_LOAD = '0;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t result;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Predicted state of the block.
  logic [1:0]  phase_q;
  logic [15:0] ptr_q;
  logic [15:0] adc_q [NumChannelsDefault];

  out_item_t tx_words_due [$];
  plan_row_t directed_plan [$];
  int        mismatches = 0;
  int        results_taken = 0;
  int        counted_words = 0;
  int        send_calm = 0;
  int        recv_calm = 0;

  i2c_target_register_map dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Ends the run if the words stop flowing.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Byte that a read request at address a loads for transmission.
  function automatic logic [7:0] map_byte(logic [15:0] a);
    int          k;
    logic [15:0] v;
    if (a >= NAME_BASE && int'(a) < int'(NAME_BASE) + NameLengthDefault) begin
      k = int'(a - NAME_BASE);
      return (k < ID_TEXT_LEN) ? ID_TEXT[8*(ID_TEXT_LEN-1-k) +: 8] : 8'h00;
    end
    if (a >= ADC_BASE && int'(a) < int'(ADC_BASE) + 2 * NumChannelsDefault) begin
      k = int'(a - ADC_BASE);
      v = adc_q[k / 2];
      return (k % 2 == 1) ? v[7:0] : v[15:8];
    end
    return 8'h00;
  endfunction

  // Advances the predicted state by one input word and returns its result word.
  function automatic out_item_t register_map_step(in_item_t w);
    out_item_t r;
    r = NO_LOAD;
    if (w.opcode == OP_ADC_UPD) begin
      if (int'(w.channel) < NumChannelsDefault) adc_q[w.channel] = w.sample;
    end else if (w.read_not_write) begin
      if (w.data_not_address && w.master_nack) begin
        // Read completion without acknowledge.
        phase_q = PHASE_IDLE;
        ptr_q = '0;
      end else begin
        r.tx_byte = map_byte(ptr_q);
        r.tx_loaded = 1'b1;
        ptr_q = ptr_q + 16'd1;
      end
    end else if (w.data_not_address) begin
      case (phase_q)
        PHASE_IDLE: begin
          if (w.rx_byte == CMD_SET_POINTER) phase_q = PHASE_PTR_HI;
        end
        PHASE_PTR_HI: begin
          ptr_q = {8'h00, w.rx_byte};
          phase_q = PHASE_PTR_LO;
        end
        PHASE_PTR_LO: begin
          ptr_q = {ptr_q[7:0], w.rx_byte};
          phase_q = PHASE_DONE;
        end
        default: begin
          phase_q = PHASE_IDLE;
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t bus_word(bit rnw, bit dna, bit nack, logic [7:0] rx);
    in_item_t w;
    w.opcode = OP_BUS_EVENT;
    w.read_not_write = rnw;
    w.data_not_address = dna;
    w.master_nack = nack;
    w.rx_byte = rx;
    w.channel = 2'($urandom_range(0, 3));
    w.sample = 16'($urandom);
    return w;
  endfunction

  function automatic in_item_t adc_word(logic [1:0] ch, logic [15:0] smp);
    in_item_t w;
    logic [31:0] r;
    r = $urandom;
    w = r[29:0];
    w.opcode = OP_ADC_UPD;
    w.channel = ch;
    w.sample = smp;
    return w;
  endfunction

  function automatic out_item_t tx_of(logic [7:0] b);
    return {b, 1'b1};
  endfunction

  // Pointer targets that sit on the edges of the map most of the time.
  function automatic logic [15:0] pick_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'h001E + 16'($urandom_range(0, 15));
    if (sel < 7) return 16'h005E + 16'($urandom_range(0, 11));
    if (sel == 7) return 16'hFFF0 + 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // Idle cycles before the next word: calm stretches of zero, else mostly short gaps.
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      gap = 0;
    end else if ($urandom_range(0, 1) == 0) begin
      gap = $urandom_range(0, 18);
    end else begin
      gap = $urandom_range(0, 3);
    end
  endtask

  task automatic add_row(in_item_t w, bit typed, out_item_t result);
    plan_row_t row;
    row.word = w;
    row.typed = typed;
    row.result = result;
    directed_plan.push_back(row);
  endtask

  // Offers one word, holds it until taken, then records what must come back.
  task automatic offer_word(input in_item_t w, input bit typed = 1'b0,
                            input out_item_t typed_result = '0);
    int        gap;
    out_item_t predicted;
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_stall);
    predicted = register_map_step(w);
    tx_words_due.push_back(typed ? typed_result : predicted);
    counted_words++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (tx_words_due.size() == 0) begin
      if (mismatches < 10)
        $display("result word %0d arrived with none due: tx_byte=%02h tx_loaded=%0b",
                 results_taken, got.tx_byte, got.tx_loaded);
      mismatches++;
    end else begin
      want = tx_words_due.pop_front();
      if (got.tx_byte !== want.tx_byte || got.tx_loaded !== want.tx_loaded) begin
        if (mismatches < 10)
          $display("result word %0d: expected tx_byte=%02h tx_loaded=%0b, got %02h %0b",
                   results_taken, want.tx_byte, want.tx_loaded, got.tx_byte,
                   got.tx_loaded);
        mismatches++;
      end
    end
  endtask

  // Receiver: stalls at random, once for a long stretch so the block backs up.
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      draw_gap(recv_calm, n);
      if (results_taken == 400) n = 150;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      check_result(out_item);
      results_taken++;
    end
  end

  // Sender and end of run.
  initial begin
    int          kind;
    int          burst;
    bit          dna;
    logic [15:0] addr;
    logic [31:0] r;

    phase_q = PHASE_IDLE;
    ptr_q = '0;
    foreach (adc_q[i]) adc_q[i] = '0;

    // Directed table: word, whether the result is written out, the result.
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'h00));   // read right after reset
    add_row(adc_word(2'd0, 16'hFFFF), 1, NO_LOAD);
    add_row(adc_word(2'd1, 16'hA55A), 0, NO_LOAD);
    add_row(bus_word(0, 0, 1, 8'hFF), 1, NO_LOAD);        // write address event
    add_row(bus_word(0, 1, 0, 8'h02), 1, NO_LOAD);        // idle, not a command byte
    add_row(bus_word(0, 1, 0, CMD_SET_POINTER), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h00), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h20), 1, NO_LOAD);
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'h42));   // first name byte
    add_row(bus_word(1, 1, 0, 8'hFF), 1, tx_of(8'h63));
    add_row(bus_word(0, 1, 1, 8'hAA), 1, NO_LOAD);        // fourth byte ends the phase
    add_row(bus_word(0, 1, 0, CMD_SET_POINTER), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h00), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h2B), 1, NO_LOAD);
    add_row(bus_word(1, 0, 1, 8'h00), 1, tx_of(8'h31));   // last name byte
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'h00));   // just past the name
    add_row(bus_word(1, 1, 1, 8'h00), 1, NO_LOAD);        // read completion, no ack
    add_row(bus_word(0, 1, 0, CMD_SET_POINTER), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h00), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'h60), 1, NO_LOAD);
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'hFF));   // channel 0 high byte
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'hFF));
    add_row(bus_word(1, 0, 0, 8'h00), 0, NO_LOAD);        // channel 1 high byte
    add_row(bus_word(0, 1, 0, 8'h00), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, CMD_SET_POINTER), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'hFF), 1, NO_LOAD);
    add_row(bus_word(0, 1, 0, 8'hFF), 1, NO_LOAD);
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'h00));   // top address, pointer wraps
    add_row(bus_word(1, 0, 0, 8'h00), 1, tx_of(8'h00));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      offer_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].result);

    while (counted_words < 1200) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Well-formed pointer load, then a read burst from the new pointer.
        while (phase_q != PHASE_IDLE)
          offer_word(bus_word(0, 1, 1'($urandom_range(0, 1)), 8'($urandom)));
        addr = pick_address();
        offer_word(bus_word(0, 1, 1'($urandom_range(0, 1)), CMD_SET_POINTER));
        offer_word(bus_word(0, 1, 1'($urandom_range(0, 1)), addr[15:8]));
        offer_word(bus_word(0, 1, 1'($urandom_range(0, 1)), addr[7:0]));
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          dna = 1'($urandom_range(0, 1));
          offer_word(bus_word(1, dna, dna ? 1'b0 : 1'($urandom_range(0, 1)),
                              8'($urandom)));
        end
        if ($urandom_range(0, 1) == 1)
          offer_word(bus_word(0, 1, 1'($urandom_range(0, 1)), 8'($urandom)));
      end else if (kind < 55) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          dna = 1'($urandom_range(0, 1));
          offer_word(bus_word(1, dna, dna ? 1'b0 : 1'($urandom_range(0, 1)),
                              8'($urandom)));
        end
      end else if (kind < 70) begin
        offer_word(adc_word(2'($urandom_range(0, 3)), 16'($urandom)));
      end else if (kind < 78) begin
        offer_word(bus_word(1, 1, 1, 8'($urandom)));
      end else if (kind < 86) begin
        offer_word(bus_word(0, 0, 1'($urandom_range(0, 1)), 8'($urandom)));
      end else begin
        r = $urandom;
        offer_word(in_item_t'(r[29:0]));
      end
    end
    in_valid <= 1'b0;

    // Drain, then give any stray word time to show up.
    while (tx_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
